FILE: rtl/cab_pkg.sv
// shared types, codes and default sizes for the cache bank
package cab_pkg;

    // default sizes
    localparam int CAB_WAYS        = 4;
    localparam int CAB_SETS        = 64;
    localparam int CAB_MSHR_DEPTH  = 16;
    localparam int CAB_ADDR_BITS   = 32;
    localparam int CAB_OFFSET_BITS = 6;
    localparam int CAB_BANK_W      = 2;

    // most results released by one fill
    localparam int CAB_MAX_RESULTS = 16;
    localparam int AGE_W           = 8;

    // request opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_RESP    = 2'd0;
    localparam logic [1:0] KIND_FILLREQ = 2'd1;
    localparam logic [1:0] KIND_MEMWR   = 2'd2;
    localparam logic [1:0] KIND_STALL   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WRITE_THROUGH  = 2'd0;
    localparam logic [1:0] CFG_WRITE_RESPONSE = 2'd1;
    localparam logic [1:0] CFG_BANK_INDEX     = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REQ,
        ST_EMIT,
        ST_FMARK,
        ST_FWRITE,
        ST_SCAN
    } state_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [3:0]  entry;
        logic [15:0] rtag;
        logic [3:0]  port;
        logic [3:0]  core;
    } res_t;

    // commands to the miss holding registers
    typedef struct packed {
        logic alloc;
        logic mark;
        logic release_en;
    } mshr_ctrl_t;

endpackage

FILE: rtl/cab_ram.sv
// generic single-port-write ram with registered read
module cab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/cab_mshr.sv
// miss holding registers with parallel line match and replay marks
module cab_mshr
    import cab_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int TAG_W = 18,
    parameter int SET_W = 6,
    parameter int WAY_W = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mshr_ctrl_t                            ctrl,
    input  logic [TAG_W-1:0]                      lookup_tag,
    input  logic [SET_W-1:0]                      lookup_set,
    input  logic [WAY_W-1:0]                      alloc_way,
    input  logic [15:0]                           alloc_rtag,
    input  logic [3:0]                            alloc_port,
    input  logic [3:0]                            alloc_core,
    input  logic                                  alloc_write,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] release_idx,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_idx,
    output logic [DEPTH-1:0]                      valid,
    output logic [DEPTH-1:0]                      match,
    output logic [DEPTH-1:0]                      replay,
    output logic                                  full,
    output logic                                  any_write,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] free_idx,
    output logic [TAG_W-1:0]                      rd_tag,
    output logic [SET_W-1:0]                      rd_set,
    output logic [WAY_W-1:0]                      rd_way,
    output logic [15:0]                           rd_rtag,
    output logic [3:0]                            rd_port,
    output logic [3:0]                            rd_core
);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DEPTH-1:0] replay_reg;
    logic [DEPTH-1:0] replay_next;
    logic [TAG_W-1:0] tag_reg  [DEPTH];
    logic [SET_W-1:0] set_reg  [DEPTH];
    logic [WAY_W-1:0] way_reg  [DEPTH];
    logic [15:0]      rtag_reg [DEPTH];
    logic [3:0]       port_reg [DEPTH];
    logic [3:0]       core_reg [DEPTH];
    logic [DEPTH-1:0] write_reg;

    // line match and lowest free entry
    always_comb
    begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == lookup_tag) && (set_reg[i] == lookup_set);
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign valid     = valid_reg;
    assign replay    = replay_reg;
    assign full      = &valid_reg;
    assign any_write = |(match & write_reg);

    // entry read
    assign rd_tag  = tag_reg[rd_idx];
    assign rd_set  = set_reg[rd_idx];
    assign rd_way  = way_reg[rd_idx];
    assign rd_rtag = rtag_reg[rd_idx];
    assign rd_port = port_reg[rd_idx];
    assign rd_core = core_reg[rd_idx];

    // valid and replay updates
    always_comb
    begin
        valid_next  = valid_reg;
        replay_next = replay_reg;
        if (ctrl.mark)
        begin
            replay_next = replay_reg | match;
        end
        if (ctrl.alloc)
        begin
            valid_next[free_idx]  = 1'b1;
            replay_next[free_idx] = 1'b0;
        end
        if (ctrl.release_en)
        begin
            valid_next[release_idx]  = 1'b0;
            replay_next[release_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            replay_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            replay_reg <= replay_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (ctrl.alloc)
        begin
            tag_reg[free_idx]   <= lookup_tag;
            set_reg[free_idx]   <= lookup_set;
            way_reg[free_idx]   <= alloc_way;
            rtag_reg[free_idx]  <= alloc_rtag;
            port_reg[free_idx]  <= alloc_port;
            core_reg[free_idx]  <= alloc_core;
            write_reg[free_idx] <= alloc_write;
        end
    end

    // allocation only into a free entry
    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.alloc |-> !full)
        else $error("mshr allocation while full");

    // a released entry was live
    a_release_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.release_en |-> valid_reg[release_idx] && replay_reg[release_idx])
        else $error("mshr release of idle entry");

    // a marked entry becomes a replay
    a_mark: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mark && !ctrl.release_en |=> ((replay_reg & $past(match)) == $past(match)))
        else $error("mshr mark lost");
endmodule

FILE: rtl/set_assoc_cache_bank_with_mshr_core.sv
// top level of one set-associative non-blocking cache bank with miss holding registers
//
// Channels: the slave stream s_* carries one request per transfer (read, write or
// memory fill); the master stream m_* carries result items, m_tuser holding the
// result kind and m_tlast marking the final result of one input transfer. The
// cfg_* port writes the three mode registers; the user must write them only while
// the bank is idle, which the block itself does not enforce. A read or write
// takes the set row out of the tag ram, is evaluated and, unless it stalls on full
// miss entries, written back in the next cycle, then hands its zero to two results
// to the output register one per cycle while the receiver takes them. A fill of a
// valid miss entry reads that entry, installs the line with one ram read and one
// write, then scans the miss entries one per cycle while the receiver takes
// results, up to the last merged one or the sixteenth result, releasing each merged
// request as a response; one input is worked on at a time. After reset the bank
// clears the tag ram, one set per cycle, and takes no input transfer until done;
// configuration writes are taken always. When the receiver stalls, the result
// waits in the output register and the sequencer holds until it is taken.
module set_assoc_cache_bank_with_mshr_core
    import cab_pkg::*;
#(
    parameter int WAYS             = CAB_WAYS,
    parameter int SETS             = CAB_SETS,
    parameter int MSHR_DEPTH       = CAB_MSHR_DEPTH,
    parameter int ADDR_BITS        = CAB_ADDR_BITS,
    parameter int LINE_OFFSET_BITS = CAB_OFFSET_BITS,
    parameter int BANK_W           = CAB_BANK_W
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode, address, request_tag, requester, core_number, fill_entry, zero pad
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // memory_address, memory_entry, response_tag, response_port, response_core, zero pad
    output logic [63:0] m_tdata,
    // kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    localparam int SET_BITS   = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int SET_W      = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_W      = (MSHR_DEPTH > 1) ? $clog2(MSHR_DEPTH) : 1;
    localparam int SET_SHIFT  = LINE_OFFSET_BITS + BANK_W;
    localparam int TAG_SHIFT  = SET_SHIFT + SET_BITS;
    localparam int TAG_W      = (ADDR_BITS > TAG_SHIFT) ? ADDR_BITS - TAG_SHIFT : 1;
    localparam int WAY_BITS   = TAG_W + 2 + AGE_W;
    localparam int ROW_W      = WAYS * WAY_BITS;
    localparam logic [63:0] ADDR_MASK =
        (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [63:0] SET_MASK  = (64'd1 << SET_BITS) - 64'd1;
    localparam logic [63:0] BANK_MASK = (64'd1 << BANK_W) - 64'd1;
    localparam logic [63:0] TAG_MASK  =
        (ADDR_BITS > TAG_SHIFT) ? ((ADDR_BITS - TAG_SHIFT >= 64) ? '1 :
        ((64'd1 << (ADDR_BITS - TAG_SHIFT)) - 64'd1)) : 64'd0;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic       wt_reg;
    logic       wr_reg;
    logic [1:0] bank_reg;

    // request and fill context
    logic             req_write_reg;
    logic [TAG_W-1:0] req_tag_reg;
    logic [SET_W-1:0] req_set_reg;
    logic [15:0]      req_rtag_reg;
    logic [3:0]       req_port_reg;
    logic [3:0]       req_core_reg;
    logic [TAG_W-1:0] root_tag_reg;
    logic [SET_W-1:0] root_set_reg;
    logic [WAY_W-1:0] root_way_reg;
    logic             fill_dirty_reg;

    // pending results of a request
    res_t       res0_reg;
    res_t       res1_reg;
    logic [1:0] res_cnt_reg;
    logic       res_idx_reg;

    logic [IDX_W-1:0] scan_idx_reg;
    logic [4:0]       emit_cnt_reg;
    logic [SET_W-1:0] clr_reg;

    // output register
    logic out_valid_reg;
    res_t out_reg;
    logic out_last_reg;

    // input decode
    logic             in_accept;
    logic [1:0]       in_op;
    logic [63:0]      in_addr;
    logic [63:0]      in_set_raw;
    logic [SET_W-1:0] in_set;
    logic [TAG_W-1:0] in_tag;
    logic [6:0]       in_id;
    logic             in_id_ok;

    // ram
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [SET_W-1:0] ram_raddr;
    logic [ROW_W-1:0] ram_rdata;

    // mshr
    mshr_ctrl_t            mctrl;
    logic [TAG_W-1:0]      lk_tag;
    logic [SET_W-1:0]      lk_set;
    logic [IDX_W-1:0]      m_rd_idx;
    logic [MSHR_DEPTH-1:0] m_valid;
    logic [MSHR_DEPTH-1:0] m_match;
    logic [MSHR_DEPTH-1:0] m_replay;
    logic                  m_full;
    logic                  m_any_write;
    logic [IDX_W-1:0]      m_free_idx;
    logic [TAG_W-1:0]      m_rd_tag;
    logic [SET_W-1:0]      m_rd_set;
    logic [WAY_W-1:0]      m_rd_way;
    logic [15:0]           m_rd_rtag;
    logic [3:0]            m_rd_port;
    logic [3:0]            m_rd_core;

    // evaluation
    logic             e_stall;
    logic             e_alloc;
    logic [WAY_W-1:0] e_victim;
    logic [ROW_W-1:0] e_row;
    res_t             e_res0;
    res_t             e_res1;
    logic [1:0]       e_cnt;
    logic [ROW_W-1:0] f_row;

    // output control
    logic out_free;
    logic load_out;
    res_t load_res;
    logic load_last;
    logic scan_take;
    logic scan_last;
    logic scan_more;
    logic scan_done;

    // line address from set and tag
    function automatic logic [31:0] line_addr(input logic [SET_W-1:0] set,
                                              input logic [TAG_W-1:0] tag,
                                              input logic [1:0] bank);
        logic [63:0] a;
        a = ((64'(bank) & BANK_MASK) << LINE_OFFSET_BITS)
          | ((64'(set) & SET_MASK) << SET_SHIFT)
          | ((64'(tag) & TAG_MASK) << TAG_SHIFT);
        a = a & ADDR_MASK;
        return a[31:0];
    endfunction

    // input field decode
    always_comb
    begin
        in_op      = s_tdata[1:0];
        in_addr    = 64'(s_tdata[33:2]) & ADDR_MASK;
        in_set_raw = (in_addr >> SET_SHIFT) & SET_MASK;
        in_set     = (in_set_raw >= 64'(SETS)) ? SET_W'(in_set_raw - 64'(SETS))
                                               : SET_W'(in_set_raw);
        in_tag     = TAG_W'((in_addr >> TAG_SHIFT) & TAG_MASK);
        in_id      = 7'(s_tdata[61:58]);
        in_id_ok   = (in_id < 7'(MSHR_DEPTH)) && m_valid[in_id[IDX_W-1:0]];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_reg   <= 1'b0;
            wr_reg   <= 1'b0;
            bank_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_WRITE_THROUGH:  wt_reg   <= cfg_wdata[0];
                CFG_WRITE_RESPONSE: wr_reg   <= cfg_wdata[0];
                CFG_BANK_INDEX:     bank_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // request evaluation against the set row
    always_comb
    begin
        logic [WAYS-1:0]       w_valid;
        logic [WAYS-1:0]       w_dirty;
        logic [WAYS-1:0]       w_match;
        logic [AGE_W-1:0]      w_age  [WAYS];
        logic [TAG_W-1:0]      w_tag  [WAYS];
        logic [WAYS-1:0]       w_dirty_new;
        logic                  hit;
        logic                  freeway;
        logic [WAY_W-1:0]      hitway;
        logic [WAY_W-1:0]      freeidx;
        logic [WAY_W-1:0]      maxidx;
        logic [AGE_W-1:0]      maxage;
        res_t                  resp;
        res_t                  r0;
        res_t                  r1;
        logic [1:0]            cnt;
        logic                  pending;

        hit = 1'b0;
        hitway = '0;
        freeway = 1'b0;
        freeidx = '0;
        e_row = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            w_valid[w] = ram_rdata[w*WAY_BITS];
            w_dirty[w] = ram_rdata[w*WAY_BITS + 1];
            w_age[w]   = ram_rdata[w*WAY_BITS + 2 +: AGE_W];
            w_tag[w]   = ram_rdata[w*WAY_BITS + 2 + AGE_W +: TAG_W];
            w_match[w] = w_valid[w] && (w_tag[w] == req_tag_reg);
            if (w_match[w])
            begin
                w_age[w] = '0;
                hit      = 1'b1;
                hitway   = WAY_W'(w);
            end
            else if (w_valid[w] && (w_age[w] != AGE_MAX))
            begin
                w_age[w] = w_age[w] + 1'b1;
            end
            if (!w_valid[w])
            begin
                freeway = 1'b1;
                freeidx = WAY_W'(w);
            end
        end

        // oldest valid way
        maxage = '0;
        maxidx = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (w_age[w] > maxage)
            begin
                maxage = w_age[w];
                maxidx = WAY_W'(w);
            end
        end
        e_victim = freeway ? freeidx : maxidx;

        w_dirty_new = w_dirty;
        if (hit && req_write_reg && !wt_reg)
        begin
            w_dirty_new[hitway] = 1'b1;
        end
        for (int w = 0; w < WAYS; w++)
        begin
            e_row[w*WAY_BITS +: WAY_BITS] = {w_tag[w], w_age[w], w_dirty_new[w], w_valid[w]};
        end

        resp = '{kind: KIND_RESP, addr: 32'd0, entry: 4'd0, rtag: req_rtag_reg,
                 port: req_port_reg, core: req_core_reg};
        r0 = resp;
        r1 = resp;
        cnt = 2'd0;
        e_alloc = 1'b0;
        pending = |m_match;
        e_stall = (!req_write_reg || !wt_reg) && m_full;

        if (e_stall)
        begin
            r0.kind = KIND_STALL;
            cnt = 2'd1;
        end
        else if (hit)
        begin
            if (req_write_reg && wt_reg)
            begin
                r0 = '{kind: KIND_MEMWR, addr: line_addr(req_set_reg, req_tag_reg, bank_reg),
                       entry: 4'd0, rtag: 16'd0, port: 4'd0, core: req_core_reg};
                cnt = 2'd1;
                if (wr_reg)
                begin
                    cnt = 2'd2;
                end
            end
            else if (!req_write_reg || wr_reg)
            begin
                cnt = 2'd1;
            end
        end
        else
        begin
            // write-back of a dirty victim goes first
            if (!freeway && !wt_reg && w_dirty[e_victim])
            begin
                r0 = '{kind: KIND_MEMWR,
                       addr: line_addr(req_set_reg, w_tag[e_victim], bank_reg),
                       entry: 4'd0, rtag: 16'd0, port: 4'd0, core: req_core_reg};
                cnt = 2'd1;
            end
            if (req_write_reg && wt_reg)
            begin
                r0 = '{kind: KIND_MEMWR, addr: line_addr(req_set_reg, req_tag_reg, bank_reg),
                       entry: 4'd0, rtag: 16'd0, port: 4'd0, core: req_core_reg};
                cnt = wr_reg ? 2'd2 : 2'd1;
            end
            else
            begin
                e_alloc = 1'b1;
                if (!pending)
                begin
                    if (cnt == 2'd0)
                    begin
                        r0 = '{kind: KIND_FILLREQ,
                               addr: line_addr(req_set_reg, req_tag_reg, bank_reg),
                               entry: 4'(m_free_idx), rtag: 16'd0, port: 4'd0,
                               core: req_core_reg};
                    end
                    else
                    begin
                        r1 = '{kind: KIND_FILLREQ,
                               addr: line_addr(req_set_reg, req_tag_reg, bank_reg),
                               entry: 4'(m_free_idx), rtag: 16'd0, port: 4'd0,
                               core: req_core_reg};
                    end
                    cnt = cnt + 2'd1;
                end
            end
        end
        e_res0 = r0;
        e_res1 = r1;
        e_cnt  = cnt;
    end

    // fill row: install the line in the held way
    always_comb
    begin
        f_row = ram_rdata;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == root_way_reg)
            begin
                f_row[w*WAY_BITS +: WAY_BITS] = {root_tag_reg, {AGE_W{1'b0}},
                                                 fill_dirty_reg, 1'b1};
            end
        end
    end

    // replay scan
    always_comb
    begin
        scan_more = 1'b0;
        for (int j = 0; j < MSHR_DEPTH; j++)
        begin
            if ((IDX_W'(j) > scan_idx_reg) && m_replay[j])
            begin
                scan_more = 1'b1;
            end
        end
        scan_take = m_replay[scan_idx_reg];
        scan_last = !scan_more || (emit_cnt_reg == 5'(CAB_MAX_RESULTS - 1));
        scan_done = (scan_take && scan_last) || (scan_idx_reg == IDX_W'(MSHR_DEPTH - 1));
    end

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if ((in_op == OP_READ) || (in_op == OP_WRITE))
                    begin
                        state_next = ST_REQ;
                    end
                    else if ((in_op == OP_FILL) && in_id_ok)
                    begin
                        state_next = ST_FMARK;
                    end
                end
            end
            ST_REQ:
            begin
                state_next = (e_cnt == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free && (2'(res_idx_reg) == res_cnt_reg - 2'd1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FMARK:  state_next = ST_FWRITE;
            ST_FWRITE: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (out_free && scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = root_set_reg;
        ram_wdata       = f_row;
        ram_raddr       = root_set_reg;
        lk_tag          = root_tag_reg;
        lk_set          = root_set_reg;
        m_rd_idx        = scan_idx_reg;
        mctrl           = '0;
        load_out        = 1'b0;
        load_res        = res0_reg;
        load_last       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                ram_raddr = in_set;
                m_rd_idx  = in_id[IDX_W-1:0];
            end
            ST_REQ:
            begin
                ram_we      = !e_stall;
                ram_waddr   = req_set_reg;
                ram_wdata   = e_row;
                lk_tag      = req_tag_reg;
                lk_set      = req_set_reg;
                mctrl.alloc = e_alloc;
            end
            ST_EMIT:
            begin
                load_out  = out_free;
                load_res  = res_idx_reg ? res1_reg : res0_reg;
                load_last = (2'(res_idx_reg) == res_cnt_reg - 2'd1);
            end
            ST_FMARK:
            begin
                mctrl.mark = 1'b1;
            end
            ST_FWRITE:
            begin
                ram_we = 1'b1;
            end
            ST_SCAN:
            begin
                load_out         = out_free && scan_take;
                mctrl.release_en = out_free && scan_take;
                load_res         = '{kind: KIND_RESP, addr: 32'd0, entry: 4'd0,
                                     rtag: m_rd_rtag, port: m_rd_port, core: m_rd_core};
                load_last        = scan_last;
            end
            default: ;
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            res_idx_reg   <= 1'b0;
            scan_idx_reg  <= '0;
            emit_cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_REQ)
            begin
                res_idx_reg <= 1'b0;
            end
            else if (state_reg == ST_EMIT && out_free)
            begin
                res_idx_reg <= 1'b1;
            end
            if (state_reg == ST_FWRITE)
            begin
                scan_idx_reg <= '0;
                emit_cnt_reg <= '0;
            end
            else if (state_reg == ST_SCAN && out_free)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_take)
                begin
                    emit_cnt_reg <= emit_cnt_reg + 5'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_write_reg <= (in_op == OP_WRITE);
            req_tag_reg   <= in_tag;
            req_set_reg   <= in_set;
            req_rtag_reg  <= s_tdata[49:34];
            req_port_reg  <= s_tdata[53:50];
            req_core_reg  <= s_tdata[57:54];
            root_tag_reg  <= m_rd_tag;
            root_set_reg  <= m_rd_set;
            root_way_reg  <= m_rd_way;
        end
        if (state_reg == ST_FMARK)
        begin
            fill_dirty_reg <= m_any_write;
        end
        if (state_reg == ST_REQ)
        begin
            res0_reg    <= e_res0;
            res1_reg    <= e_res1;
            res_cnt_reg <= e_cnt;
        end
        if (load_out)
        begin
            out_reg      <= load_res;
            out_last_reg <= load_last;
        end
    end

    cab_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cab_mshr #(
        .DEPTH (MSHR_DEPTH),
        .TAG_W (TAG_W),
        .SET_W (SET_W),
        .WAY_W (WAY_W)
    ) u_mshr (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (mctrl),
        .lookup_tag  (lk_tag),
        .lookup_set  (lk_set),
        .alloc_way   (e_victim),
        .alloc_rtag  (req_rtag_reg),
        .alloc_port  (req_port_reg),
        .alloc_core  (req_core_reg),
        .alloc_write (req_write_reg),
        .release_idx (scan_idx_reg),
        .rd_idx      (m_rd_idx),
        .valid       (m_valid),
        .match       (m_match),
        .replay      (m_replay),
        .full        (m_full),
        .any_write   (m_any_write),
        .free_idx    (m_free_idx),
        .rd_tag      (m_rd_tag),
        .rd_set      (m_rd_set),
        .rd_way      (m_rd_way),
        .rd_rtag     (m_rd_rtag),
        .rd_port     (m_rd_port),
        .rd_core     (m_rd_core)
    );

    // output ports
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_reg.core, out_reg.port, out_reg.rtag, out_reg.entry,
                       out_reg.addr};

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("result register overwritten");

    // the tag ram is only written in the write-back steps
    a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR) || (state_reg == ST_REQ)
                   || (state_reg == ST_FWRITE))
        else $error("unexpected tag ram write");

    // a fill scan always starts with at least one replay entry to release
    a_scan_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FWRITE) |-> (m_replay != '0))
        else $error("fill with no replay entry");
endmodule
